// ----- rtl/lcf_pkg.sv -----
// Shared types, constants and helpers for the LED color crossfade block.
// No dependencies; every other file of the block imports this package.
package lcf_pkg;

    localparam int CHANNELS_PER_COLOR = 4;
    localparam int NLEVELS            = 9;
    localparam int BRI_IDX            = 8;
    localparam int SEC_FIRST          = 4;
    localparam int SEC_LAST           = 7;
    localparam int LVL_AW             = $clog2(NLEVELS);
    localparam int FRAC_W             = 16;
    localparam int DIV_CNT_W          = $clog2(FRAC_W + 1);
    localparam int DIV100_SHIFT       = 24;

    localparam logic [LVL_AW-1:0] LAST_IDX   = LVL_AW'(NLEVELS - 1);
    localparam logic [FRAC_W-1:0] FRAC_STEP  = 16'd262;
    localparam logic [FRAC_W:0]   FRAC_ONE   = 17'h10000;

    // floor(x / 100) == (x * DIV100_RECIP) >> 24 holds for every x below 65536.
    localparam logic [17:0] DIV100_RECIP = 18'd167773;

    localparam logic [15:0] TRANSITION_RESET  = 16'd700;
    localparam logic [7:0]  BRI_PERCENT_RESET = 8'd100;

    localparam logic [1:0] CFG_TRANSITION = 2'd0;
    localparam logic [1:0] CFG_FADE_EN    = 2'd1;
    localparam logic [1:0] CFG_BRI_PCT    = 2'd2;
    localparam logic [1:0] CFG_SEC_FADE   = 2'd3;

    localparam logic OP_TARGET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef logic [7:0] t_level;

    typedef struct packed {
        t_level start;
        t_level goal;
        t_level shown;
    } t_level_word;

    typedef struct packed {
        logic              en;
        logic [LVL_AW-1:0] addr;
        t_level_word       data;
    } t_ram_wr;

    typedef struct packed {
        logic   operation;
        t_level primary_red;
        t_level primary_green;
        t_level primary_blue;
        t_level primary_white;
        t_level second_red;
        t_level second_green;
        t_level second_blue;
        t_level second_white;
        t_level brightness;
    } t_in_item;

    typedef struct packed {
        t_level out_primary_red;
        t_level out_primary_green;
        t_level out_primary_blue;
        t_level out_primary_white;
        t_level out_second_red;
        t_level out_second_green;
        t_level out_second_blue;
        t_level out_second_white;
        t_level out_brightness;
        logic   fading;
    } t_out_item;

    // A level slot is live unless it is a white slot of a three-channel color.
    function automatic logic level_used(input logic [LVL_AW-1:0] idx);
        return (idx == LVL_AW'(BRI_IDX)) ||
               ({1'b0, idx[1:0]} < 3'(CHANNELS_PER_COLOR));
    endfunction

endpackage

// ----- rtl/lcf_in_if.sv -----
// Input channel of the LED color crossfade block: valid/ready plus one item.
// Depends on lcf_pkg for the item type.
interface lcf_in_if;
    logic              valid;
    logic              ready;
    lcf_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/lcf_out_if.sv -----
// Result channel of the LED color crossfade block: valid/ready plus one item.
// Depends on lcf_pkg for the item type.
interface lcf_out_if;
    logic               valid;
    logic               ready;
    lcf_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/lcf_level_ram.sv -----
// Level memory: start, goal and shown level of each of the nine slots.
// Depends on lcf_pkg. Registered read, valid bits give reset zeros.
module lcf_level_ram
    import lcf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [LVL_AW-1:0] i_rd_addr,
    output t_level_word       o_rd_data,
    input  t_ram_wr           i_wr
);

    t_level_word        r_mem [NLEVELS];
    logic [NLEVELS-1:0] r_valid;
    t_level_word        r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            // A write to the entry being read wins, so the read sees new data.
            if (i_wr.en && (i_wr.addr == i_rd_addr)) begin
                r_rd_data <= i_wr.data;
            end else if (r_valid[i_rd_addr]) begin
                r_rd_data <= r_mem[i_rd_addr];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/lcf_frac_div.sv -----
// Restoring divider forming the Q0.16 fade fraction elapsed * 65536 / length.
// Depends on lcf_pkg. One quotient bit per cycle; elapsed must be below length.
module lcf_frac_div
    import lcf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [15:0]       i_elapsed,
    input  logic [15:0]       i_len,
    output logic              o_done,
    output logic [FRAC_W-1:0] o_frac
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [15:0]          r_rem;
    logic [15:0]          r_len;
    logic [FRAC_W-1:0]    r_quot;
    logic [16:0]          n_shift;
    logic [16:0]          n_diff;

    assign n_shift = {r_rem, 1'b0};
    assign n_diff  = n_shift - {1'b0, r_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(FRAC_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The remainder always stays below the divisor, so 16 bits hold it.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_elapsed;
            r_len <= i_len;
        end else if (r_busy) begin
            if (!n_diff[16]) begin
                r_rem  <= n_diff[15:0];
                r_quot <= {r_quot[FRAC_W-2:0], 1'b1};
            end else begin
                r_rem  <= n_shift[15:0];
                r_quot <= {r_quot[FRAC_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_frac = r_quot;

endmodule

// ----- rtl/lcf_bri_scale.sv -----
// Brightness scaler: level * percent / 100, saturated at 255, two stages.
// Depends on lcf_pkg for the reciprocal of 100.
module lcf_bri_scale
    import lcf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_level     i_level,
    input  logic [7:0] i_percent,
    output logic       o_valid,
    output t_level     o_bri
);

    logic        r_v1;
    logic        r_v2;
    logic [15:0] r_prod;
    logic [33:0] r_scaled;
    logic [9:0]  n_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= 16'(i_level) * 16'(i_percent);
        r_scaled <= 34'(r_prod) * 34'(DIV100_RECIP);
    end

    assign n_quot  = r_scaled[DIV100_SHIFT +: 10];
    assign o_bri   = (n_quot > 10'd255) ? 8'hFF : n_quot[7:0];
    assign o_valid = r_v2;

endmodule

// ----- rtl/led_color_crossfade.sv -----
// Linear crossfade of a primary and a secondary RGBW color and a master brightness. An item is
// either a new target or a one-millisecond tick; at most one result comes out per item. The nine
// levels live in a small memory that is swept one slot per cycle, and a fade fraction comes from a
// 16-step divider. A target takes a compare sweep and, if it differs from the goal, a sweep that
// starts a fade or jumps. A tick with a fade running ends it with a sweep or runs the divider and,
// if the fraction advanced enough, an interpolation sweep. Jumps and swept ticks then scale
// brightness and give a result. A new item is taken only when the previous one is done, but a
// result may still wait in the output register. No clearing pass is needed after reset.
module led_color_crossfade
    import lcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    lcf_in_if.sink      i_in,
    lcf_out_if.source   o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_PASS = 3'd2;
    localparam logic [2:0] S_BRI  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [2:0] M_CMP      = 3'd0;
    localparam logic [2:0] M_FADE_SET = 3'd1;
    localparam logic [2:0] M_JUMP     = 3'd2;
    localparam logic [2:0] M_END      = 3'd3;
    localparam logic [2:0] M_INTERP   = 3'd4;

    // Configuration
    logic [15:0] r_transition;
    logic        r_fade_en;
    logic [7:0]  r_bri_pct;
    logic        r_sec_fade;

    // Control state
    logic [2:0]        r_state;
    logic [2:0]        r_mode;
    logic              r_rd_busy;
    logic [LVL_AW-1:0] r_rd_idx;
    logic              r_v1;
    logic              r_v2;
    logic              r_neq;
    logic              r_running;
    logic [15:0]       r_elapsed;
    logic [FRAC_W-1:0] r_last;
    logic [15:0]       r_fade_len;
    logic              r_bri_go;
    logic              r_out_valid;

    // Data path
    t_level            r_tgt [NLEVELS];
    logic [LVL_AW-1:0] r_idx1;
    logic [LVL_AW-1:0] r_idx2;
    t_level_word       r_w2;
    logic [24:0]       r_p0;
    logic [23:0]       r_p1;
    logic [FRAC_W-1:0] r_frac;
    t_level            r_stage [NLEVELS];
    logic              r_stage_fading;
    t_level            r_bri_out;
    t_out_item         r_out_data;

    t_level            in_lv [NLEVELS];
    logic              in_acc;
    logic [15:0]       n_elapsed;
    t_level_word       rd_data;
    t_ram_wr           ram_wr;
    logic [24:0]       interp_sum;
    t_level            interp_lv;
    logic              is_sec;
    logic              stage_we;
    t_level            stage_val;
    logic              neq_now;
    logic              pass_end;
    logic              div_start;
    logic              div_done;
    logic [FRAC_W-1:0] div_frac;
    logic              bri_valid;
    t_level            bri_val;

    assign in_acc    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign n_elapsed = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
    assign pass_end  = r_v2 && (r_idx2 == LAST_IDX);
    assign div_start = in_acc && (i_in.data.operation == OP_TICK) && r_running &&
                       (n_elapsed < r_fade_len);
    assign is_sec    = (r_idx2 >= LVL_AW'(SEC_FIRST)) && (r_idx2 <= LVL_AW'(SEC_LAST));

    always_comb begin
        in_lv[0] = i_in.data.primary_red;
        in_lv[1] = i_in.data.primary_green;
        in_lv[2] = i_in.data.primary_blue;
        in_lv[3] = i_in.data.primary_white;
        in_lv[4] = i_in.data.second_red;
        in_lv[5] = i_in.data.second_green;
        in_lv[6] = i_in.data.second_blue;
        in_lv[7] = i_in.data.second_white;
        in_lv[8] = i_in.data.brightness;
    end

    lcf_level_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_rd_busy),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data),
        .i_wr      (ram_wr)
    );

    lcf_frac_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_elapsed (n_elapsed),
        .i_len     (r_fade_len),
        .o_done    (div_done),
        .o_frac    (div_frac)
    );

    lcf_bri_scale u_bri (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_bri_go),
        .i_level   (r_stage[BRI_IDX]),
        .i_percent (r_bri_pct),
        .o_valid   (bri_valid),
        .o_bri     (bri_val)
    );

    // Write-back stage of the sweep: one slot per cycle, decided by the pass mode.
    always_comb begin
        ram_wr.en   = 1'b0;
        ram_wr.addr = r_idx2;
        ram_wr.data = r_w2;
        stage_we    = 1'b0;
        stage_val   = r_w2.goal;
        neq_now     = 1'b0;
        interp_sum  = r_p0 + 25'(r_p1);
        interp_lv   = interp_sum[23:16];
        if (!r_sec_fade && is_sec) begin
            interp_lv = r_w2.goal;
        end
        if (r_v2) begin
            unique case (r_mode)
                M_CMP: begin
                    neq_now = (r_w2.goal != r_tgt[r_idx2]);
                end
                M_FADE_SET: begin
                    ram_wr.en         = 1'b1;
                    ram_wr.data.start = r_w2.shown;
                    ram_wr.data.goal  = r_tgt[r_idx2];
                    ram_wr.data.shown = r_w2.shown;
                end
                M_JUMP: begin
                    ram_wr.en         = 1'b1;
                    ram_wr.data.start = r_tgt[r_idx2];
                    ram_wr.data.goal  = r_tgt[r_idx2];
                    ram_wr.data.shown = r_tgt[r_idx2];
                    stage_we          = 1'b1;
                    stage_val         = r_tgt[r_idx2];
                end
                M_END: begin
                    ram_wr.en         = 1'b1;
                    ram_wr.data.start = r_w2.goal;
                    ram_wr.data.goal  = r_w2.goal;
                    ram_wr.data.shown = r_w2.goal;
                    stage_we          = 1'b1;
                    stage_val         = r_w2.goal;
                end
                M_INTERP: begin
                    ram_wr.en         = 1'b1;
                    ram_wr.data.shown = interp_lv;
                    stage_we          = 1'b1;
                    stage_val         = interp_lv;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transition <= TRANSITION_RESET;
            r_fade_en    <= 1'b1;
            r_bri_pct    <= BRI_PERCENT_RESET;
            r_sec_fade   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TRANSITION: r_transition <= i_cfg_data;
                CFG_FADE_EN:    r_fade_en    <= i_cfg_data[0];
                CFG_BRI_PCT:    r_bri_pct    <= i_cfg_data[7:0];
                CFG_SEC_FADE:   r_sec_fade   <= i_cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_CMP;
            r_rd_busy   <= 1'b0;
            r_rd_idx    <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_neq       <= 1'b0;
            r_running   <= 1'b0;
            r_elapsed   <= '0;
            r_last      <= '0;
            r_fade_len  <= '0;
            r_bri_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_bri_go <= 1'b0;
            if (r_rd_busy) begin
                r_rd_idx <= r_rd_idx + LVL_AW'(1);
                if (r_rd_idx == LAST_IDX) begin
                    r_rd_busy <= 1'b0;
                end
            end
            r_v1 <= r_rd_busy;
            r_v2 <= r_v1;
            if (neq_now) begin
                r_neq <= 1'b1;
            end
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.data.operation == OP_TARGET) begin
                            r_mode    <= M_CMP;
                            r_neq     <= 1'b0;
                            r_rd_busy <= 1'b1;
                            r_rd_idx  <= '0;
                            r_state   <= S_PASS;
                        end else if (r_running) begin
                            r_elapsed <= n_elapsed;
                            if (n_elapsed >= r_fade_len) begin
                                r_mode    <= M_END;
                                r_running <= 1'b0;
                                r_last    <= '0;
                                r_rd_busy <= 1'b1;
                                r_rd_idx  <= '0;
                                r_state   <= S_PASS;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if ((div_frac < r_last) || ((div_frac - r_last) < FRAC_STEP)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_last    <= div_frac;
                            r_mode    <= M_INTERP;
                            r_rd_busy <= 1'b1;
                            r_rd_idx  <= '0;
                            r_state   <= S_PASS;
                        end
                    end
                end
                S_PASS: begin
                    if (pass_end) begin
                        if (r_mode == M_CMP) begin
                            if (!(r_neq || neq_now)) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_elapsed <= '0;
                                r_last    <= '0;
                                r_rd_busy <= 1'b1;
                                r_rd_idx  <= '0;
                                if (r_fade_en && (r_transition != 16'd0)) begin
                                    r_mode     <= M_FADE_SET;
                                    r_running  <= 1'b1;
                                    r_fade_len <= r_transition;
                                end else begin
                                    r_mode    <= M_JUMP;
                                    r_running <= 1'b0;
                                end
                            end
                        end else if (r_mode == M_FADE_SET) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_bri_go <= 1'b1;
                            r_state  <= S_BRI;
                        end
                    end
                end
                S_BRI: begin
                    if (bri_valid) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int i = 0; i < NLEVELS; i++) begin
                r_tgt[i] <= level_used(LVL_AW'(i)) ? in_lv[i] : 8'd0;
            end
        end
        r_idx1 <= r_rd_idx;
        r_idx2 <= r_idx1;
        r_w2   <= rd_data;
        r_p0   <= 25'(rd_data.start) * 25'(FRAC_ONE - {1'b0, r_frac});
        r_p1   <= 24'(rd_data.goal) * 24'(r_frac);
        if ((r_state == S_DIV) && div_done) begin
            r_frac <= div_frac;
        end
        if (stage_we) begin
            r_stage[r_idx2] <= stage_val;
        end
        if (pass_end) begin
            r_stage_fading <= (r_mode == M_INTERP);
        end
        if ((r_state == S_BRI) && bri_valid) begin
            r_bri_out <= bri_val;
        end
        if ((r_state == S_OUT) && (!r_out_valid || o_out.ready)) begin
            r_out_data.out_primary_red   <= r_stage[0];
            r_out_data.out_primary_green <= r_stage[1];
            r_out_data.out_primary_blue  <= r_stage[2];
            r_out_data.out_primary_white <= r_stage[3];
            r_out_data.out_second_red    <= r_stage[4];
            r_out_data.out_second_green  <= r_stage[5];
            r_out_data.out_second_blue   <= r_stage[6];
            r_out_data.out_second_white  <= r_stage[7];
            r_out_data.out_brightness    <= r_bri_out;
            r_out_data.fading            <= r_stage_fading;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule

// ----- rtl/lcf_checker.sv -----
// Port-level checks for the LED color crossfade block, bound to its top level.
// Depends on lcf_pkg for the result item type.
module lcf_checker
    import lcf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_in_op,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // A target item always starts a sweep, so the block is busy on the next cycle.
    a_busy_after_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_op == OP_TARGET) |=> !i_in_ready)
        else $error("item accepted right after a target");

    // A result needs at least a sweep of the level memory after its item.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(i_out_valid))
        else $error("result appeared right after an item");

endmodule

bind led_color_crossfade lcf_checker u_lcf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.data.operation),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ----- verif/led_color_crossfade_tb.sv -----
// Self-checking testbench for led_color_crossfade: drives targets, ticks and register writes,
// predicts every result in a scoreboard class and compares the results field by field.
// Depends on rtl/lcf_pkg.sv, rtl/lcf_in_if.sv, rtl/lcf_out_if.sv and the block itself.
module led_color_crossfade_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcf_pkg::*;

    localparam int ITEMS_PER_PHASE = 70;
    localparam int SETTLE_CYCLES   = 64;
    localparam int HOLD_CYCLES     = 600;
    localparam int STALL_LIMIT     = 5000;

    // Tracks the fade state and holds the shown levels each accepted item should produce.
    class fade_scoreboard;
        t_level      start_lv[NLEVELS];
        t_level      goal_lv[NLEVELS];
        t_level      shown_lv[NLEVELS];
        int unsigned elapsed_ms;
        int unsigned last_frac;
        int unsigned fade_len;
        bit          running;
        logic [15:0] trans_ms;
        bit          fade_on;
        logic [7:0]  bri_pct;
        bit          sec_fade;
        t_out_item   due_levels_q[$];
        int          mismatches;

        function new();
            trans_ms = TRANSITION_RESET;
            fade_on  = 1'b1;
            bri_pct  = BRI_PERCENT_RESET;
            sec_fade = 1'b1;
            foreach (start_lv[i]) begin
                start_lv[i] = '0;
                goal_lv[i]  = '0;
                shown_lv[i] = '0;
            end
            elapsed_ms = 0;
            last_frac  = 0;
            fade_len   = 0;
            running    = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_TRANSITION: trans_ms = val;
                CFG_FADE_EN:    fade_on  = val[0];
                CFG_BRI_PCT:    bri_pct  = val[7:0];
                CFG_SEC_FADE:   sec_fade = val[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_levels_q.size();
        endfunction

        function void push_levels(bit still);
            t_out_item   r;
            int unsigned b;
            r.out_primary_red   = shown_lv[0];
            r.out_primary_green = shown_lv[1];
            r.out_primary_blue  = shown_lv[2];
            r.out_primary_white = shown_lv[3];
            r.out_second_red    = shown_lv[4];
            r.out_second_green  = shown_lv[5];
            r.out_second_blue   = shown_lv[6];
            r.out_second_white  = shown_lv[7];
            b = (int'(shown_lv[BRI_IDX]) * int'(bri_pct)) / 100;
            r.out_brightness = (b > 255) ? 8'hFF : b[7:0];
            r.fading = still;
            due_levels_q.push_back(r);
        endfunction

        function void show_goal();
            foreach (goal_lv[i]) begin
                shown_lv[i] = goal_lv[i];
                start_lv[i] = goal_lv[i];
            end
        endfunction

        function void apply_item(t_in_item it);
            t_level      raw[NLEVELS];
            t_level      tgt[NLEVELS];
            bit          same;
            int unsigned frac;
            longint      s;
            longint      d;
            longint      v;
            raw = '{it.primary_red, it.primary_green, it.primary_blue, it.primary_white,
                    it.second_red, it.second_green, it.second_blue, it.second_white,
                    it.brightness};
            if (it.operation == OP_TARGET) begin
                same = 1'b1;
                for (int i = 0; i < NLEVELS; i++) begin
                    // White slots of a three-channel color are forced to zero.
                    tgt[i] = ((i == BRI_IDX) || ((i % 4) < CHANNELS_PER_COLOR)) ? raw[i] : '0;
                    if (tgt[i] != goal_lv[i]) same = 1'b0;
                end
                if (same) return;
                foreach (tgt[i]) goal_lv[i] = tgt[i];
                last_frac  = 0;
                elapsed_ms = 0;
                if (fade_on && trans_ms != 0) begin
                    foreach (shown_lv[i]) start_lv[i] = shown_lv[i];
                    fade_len = trans_ms;
                    running  = 1'b1;
                    return;
                end
                running = 1'b0;
                show_goal();
                push_levels(1'b0);
                return;
            end
            if (!running || fade_len == 0) return;
            if (elapsed_ms < 32'hFFFF) elapsed_ms++;
            if (elapsed_ms >= fade_len) begin
                running   = 1'b0;
                last_frac = 0;
                show_goal();
                push_levels(1'b0);
                return;
            end
            frac = (elapsed_ms << 16) / fade_len;
            if (frac < last_frac || frac - last_frac < FRAC_STEP) return;
            last_frac = frac & 32'hFFFF;
            for (int i = 0; i < NLEVELS; i++) begin
                s = start_lv[i];
                d = longint'(goal_lv[i]) - s;
                v = s * 65536 + d * longint'(frac);
                if (v < 0) v = 0;
                shown_lv[i] = t_level'(v / 65536);
            end
            if (!sec_fade) begin
                for (int i = SEC_FIRST; i <= SEC_LAST; i++) shown_lv[i] = goal_lv[i];
            end
            push_levels(1'b1);
        endfunction

        function void check_levels(t_out_item got);
            t_out_item exp_r;
            string     bad;
            if (due_levels_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: got %p", got);
                return;
            end
            exp_r = due_levels_q.pop_front();
            bad = "";
            if (got.out_primary_red   !== exp_r.out_primary_red)   bad = {bad, " primary_red"};
            if (got.out_primary_green !== exp_r.out_primary_green) bad = {bad, " primary_green"};
            if (got.out_primary_blue  !== exp_r.out_primary_blue)  bad = {bad, " primary_blue"};
            if (got.out_primary_white !== exp_r.out_primary_white) bad = {bad, " primary_white"};
            if (got.out_second_red    !== exp_r.out_second_red)    bad = {bad, " second_red"};
            if (got.out_second_green  !== exp_r.out_second_green)  bad = {bad, " second_green"};
            if (got.out_second_blue   !== exp_r.out_second_blue)   bad = {bad, " second_blue"};
            if (got.out_second_white  !== exp_r.out_second_white)  bad = {bad, " second_white"};
            if (got.out_brightness    !== exp_r.out_brightness)    bad = {bad, " brightness"};
            if (got.fading            !== exp_r.fading)            bad = {bad, " fading"};
            if (bad != "") begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch in%s: expected %p, got %p", bad, exp_r, got);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    lcf_in_if  in_if();
    lcf_out_if out_if();

    fade_scoreboard sb = new();

    int       tx_idle_pct = 0;
    int       rx_idle_pct = 0;
    bit       hold_req    = 1'b0;
    t_in_item last_target;

    led_color_crossfade dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Both channels are sampled at the clock edge, before any driver update lands.
    always @(posedge i_clk) begin
        if (in_if.valid && in_if.ready) sb.apply_item(in_if.data);
        if (out_if.valid && out_if.ready) sb.check_levels(out_if.data);
    end

    initial begin : result_sink
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
            else quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic t_in_item level_fill(t_level lv);
        return {OP_TARGET, {NLEVELS{lv}}};
    endfunction

    function automatic t_in_item tick_item();
        return {OP_TICK, 8'($urandom), $urandom, $urandom};
    endfunction

    function automatic t_in_item random_target();
        int pick;
        pick = $urandom_range(15);
        if (pick == 0) return level_fill(8'hFF);
        if (pick == 1) return level_fill(8'h00);
        return {OP_TARGET, 8'($urandom), $urandom, $urandom};
    endfunction

    // Same levels as the current goal except one slot.
    function automatic t_in_item tweak_target();
        logic [8*NLEVELS-1:0] lv;
        int                   k;
        lv = last_target[8*NLEVELS-1:0];
        k  = $urandom_range(NLEVELS - 1);
        lv[8*k +: 8] = 8'($urandom);
        return {OP_TARGET, lv};
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Narrow registers get junk in their unused upper bits.
    task automatic apply_config(input logic [15:0] tr, input bit fade, input logic [7:0] pct,
                                input bit sec);
        write_reg(CFG_TRANSITION, tr);
        write_reg(CFG_FADE_EN, {15'($urandom), fade});
        write_reg(CFG_BRI_PCT, {8'($urandom), pct});
        write_reg(CFG_SEC_FADE, {15'($urandom), sec});
    endtask

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (it.operation == OP_TARGET) last_target = it;
    endtask

    // A target may still be in work with nothing due, so wait out the item latency too.
    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [15:0] tr;
        bit          fade;
        logic [7:0]  pct;
        bit          sec;
        int          n;
        int          pick;
        int          ticks;
        bit          first_seq;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_TRANSITION;
        i_cfg_data  = '0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        last_target = level_fill(8'h00);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: tick with no fade, target equal to the goal, then a 700 ms fade.
        send_item(tick_item());
        send_item(level_fill(8'h00));
        send_item(level_fill(8'hFF));
        repeat (3) send_item(tick_item());
        settle();

        // Restart a running fade with a short duration and the secondary snapping to goal.
        write_reg(CFG_TRANSITION, 16'd3);
        write_reg(CFG_BRI_PCT, 16'hA5FF);
        write_reg(CFG_SEC_FADE, 16'hFFFE);
        send_item(level_fill(8'h00));
        repeat (4) send_item(tick_item());
        send_item({OP_TARGET, {4{8'h55}}, {4{8'hAA}}, 8'h80});
        send_item(tick_item());
        settle();

        // The running fade keeps its latched duration.
        write_reg(CFG_TRANSITION, 16'hFFFF);
        send_item(tick_item());
        settle();

        // Jump while a fade is in progress, then jumps with a zero duration.
        write_reg(CFG_FADE_EN, 16'h0000);
        send_item(level_fill(8'hFF));
        send_item(random_target());
        settle();
        write_reg(CFG_FADE_EN, 16'h0001);
        write_reg(CFG_TRANSITION, 16'h0000);
        send_item(random_target());
        send_item(tick_item());
        settle();
        write_reg(CFG_TRANSITION, 16'd2);
        write_reg(CFG_BRI_PCT, 16'd100);
        send_item(level_fill(8'h00));
        repeat (2) send_item(tick_item());
        settle();

        for (int phase = 0; phase < 9; phase++) begin
            tx_idle_pct = (phase < 3) ? 29 : (phase < 6) ? 54 : 0;
            rx_idle_pct = (phase < 3) ? 54 : (phase < 6) ? 29 : 0;
            case (phase)
                0: begin tr = 16'd1; fade = 1'b1; pct = 8'd0; sec = 1'b1; end
                1: begin tr = 16'd0; fade = 1'b1; pct = 8'd255; sec = 1'b0; end
                2: begin tr = 16'hFFFF; fade = 1'b1; pct = 8'($urandom); sec = 1'b0; end
                3: begin
                    tr = 16'($urandom_range(2, 40)); fade = 1'b0;
                    pct = 8'($urandom); sec = 1'b1;
                end
                4: begin
                    tr = 16'($urandom_range(2, 10)); fade = 1'b1;
                    pct = 8'($urandom); sec = 1'($urandom);
                end
                default: begin
                    tr = ($urandom_range(4) == 0) ? 16'($urandom_range(200, 700))
                                                  : 16'($urandom_range(2, 40));
                    fade = ($urandom_range(5) != 0);
                    pct  = 8'($urandom);
                    sec  = 1'($urandom);
                end
            endcase
            apply_config(tr, fade, pct, sec);
            // The result side stops for a long stretch while items keep coming.
            if (phase == 4) hold_req = 1'b1;
            n = 0;
            first_seq = 1'b1;
            while (n < ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 6) begin
                    send_item(last_target);
                end else if (pick < 10) begin
                    send_item(tick_item());
                end else begin
                    send_item((pick < 30) ? tweak_target() : random_target());
                    n++;
                    if (tr == 16'hFFFF && first_seq) ticks = 270;
                    else ticks = $urandom_range(0, (tr < 58) ? int'(tr) + 2 : 60);
                    first_seq = 1'b0;
                    repeat (ticks) begin
                        send_item(tick_item());
                        n++;
                    end
                end
            end
            settle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
